>>> rtl/core/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and codes of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int FRAME_W = 16;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_ACK     = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_NEW    = 2'd0;
    localparam logic [1:0] KIND_RESEND = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam logic CFG_TOTAL_FRAMES = 1'b0;
    localparam logic CFG_WINDOW_SIZE  = 1'b1;

    localparam logic [15:0] TOTAL_FRAMES_RST = 16'd16;
    localparam logic [4:0]  WINDOW_SIZE_RST  = 5'd4;

    typedef struct packed {
        logic [1:0]         command;
        logic [FRAME_W-1:0] ack_frame;
    } cmd_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_number;
        logic [1:0]         send_kind;
        logic               last;
    } send_item_t;

    typedef struct packed {
        logic take;
        logic start_init;
        logic scan_first;
        logic scan_next;
        logic scan_step;
        logic ack_clear;
        logic send_new;
        logic send_resend;
        logic send_done;
        logic last;
    } srsw_ctl_t;

    typedef struct packed {
        logic [1:0] command;
        logic       active;
        logic       total_zero;
        logic       win_last;
        logic       more_new;
        logic       new_is_last;
        logic       ack_done;
        logic       scan_hit;
        logic       scan_end;
        logic       has1;
        logic       has2;
        logic       can_load;
    } srsw_sts_t;

endpackage

>>> rtl/core/srsw_datapath.sv
// ----------------------------------------------------------------------------
// srsw_datapath
// Pending-frame table, counters, configuration, scan unit and output register.
// ----------------------------------------------------------------------------
module srsw_datapath #(
    parameter int MAX_WINDOW        = 16,
    parameter int FRAME_NUMBER_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    input  srsw_pkg::cmd_item_t  cmd_item,
    input  srsw_pkg::srsw_ctl_t  ctl,
    output srsw_pkg::srsw_sts_t  sts,
    output logic                 send_valid,
    input  logic                 send_stall,
    output srsw_pkg::send_item_t send_item
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_WINDOW - 1);

    logic [15:0]                  total_frames_reg, total_frames_next;
    logic [4:0]                   window_size_reg, window_size_next;
    srsw_pkg::cmd_item_t          item_reg;
    logic [FRAME_NUMBER_BITS-1:0] pend_num_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]        valid_reg, valid_next;
    logic [15:0]                  next_new_reg, next_new_next;
    logic [15:0]                  acked_reg, acked_next;
    logic                         active_reg, active_next;
    logic [4:0]                   win_cnt_reg, win_cnt_next;
    logic [IDX_W-1:0]             scan_idx_reg, scan_idx_next;
    logic [FRAME_NUMBER_BITS-1:0] min1_reg, min1_next;
    logic [FRAME_NUMBER_BITS-1:0] min2_reg, min2_next;
    logic                         has1_reg, has1_next;
    logic                         has2_reg, has2_next;
    logic [FRAME_NUMBER_BITS-1:0] prev_reg, prev_next;
    logic                         have_prev_reg, have_prev_next;
    logic                         out_valid_reg, out_valid_next;
    srsw_pkg::send_item_t         out_item_reg, out_item_next;

    logic                         free_found;
    logic [IDX_W-1:0]             free_idx;
    logic [4:0]                   win_clamped;
    logic [FRAME_NUMBER_BITS-1:0] scan_num;
    logic [FRAME_NUMBER_BITS-1:0] ack_num;
    logic                         cand;
    logic [15:0]                  acked_inc;
    logic [15:0]                  next_new_inc;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_WINDOW - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (window_size_reg == 5'd0)
        begin
            win_clamped = 5'd1;
        end
        else if (int'(window_size_reg) > MAX_WINDOW)
        begin
            win_clamped = 5'(MAX_WINDOW);
        end
        else
        begin
            win_clamped = window_size_reg;
        end
    end

    assign scan_num     = pend_num_mem[scan_idx_reg];
    assign ack_num      = FRAME_NUMBER_BITS'(item_reg.ack_frame);
    assign cand         = valid_reg[scan_idx_reg] && (!have_prev_reg || scan_num > prev_reg);
    assign acked_inc    = acked_reg + 16'd1;
    assign next_new_inc = next_new_reg + 16'd1;

    always_comb
    begin
        sts             = '0;
        sts.command     = item_reg.command;
        sts.active      = active_reg;
        sts.total_zero  = (total_frames_reg == 16'd0);
        sts.win_last    = (win_cnt_reg == 5'd1);
        sts.more_new    = (next_new_reg < total_frames_reg);
        sts.new_is_last = (next_new_inc >= total_frames_reg);
        sts.ack_done    = (acked_inc >= total_frames_reg);
        sts.scan_hit    = valid_reg[scan_idx_reg] && (scan_num == ack_num);
        sts.scan_end    = (scan_idx_reg == IDX_LAST);
        sts.has1        = has1_reg;
        sts.has2        = has2_reg;
        sts.can_load    = !out_valid_reg || !send_stall;
    end

    // configuration
    always_comb
    begin
        total_frames_next = total_frames_reg;
        window_size_next  = window_size_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                srsw_pkg::CFG_TOTAL_FRAMES: total_frames_next = cfg_data;
                srsw_pkg::CFG_WINDOW_SIZE:  window_size_next  = cfg_data[4:0];
                default:                    total_frames_next = total_frames_reg;
            endcase
        end
    end

    // window state
    always_comb
    begin
        valid_next    = valid_reg;
        next_new_next = next_new_reg;
        acked_next    = acked_reg;
        active_next   = active_reg;
        win_cnt_next  = win_cnt_reg;
        if (ctl.start_init)
        begin
            valid_next    = '0;
            next_new_next = 16'd0;
            acked_next    = 16'd0;
            active_next   = (total_frames_reg != 16'd0);
            win_cnt_next  = win_clamped;
        end
        if (ctl.ack_clear)
        begin
            valid_next[scan_idx_reg] = 1'b0;
            acked_next               = acked_inc;
        end
        if (ctl.send_new)
        begin
            if (free_found)
            begin
                valid_next[free_idx] = 1'b1;
            end
            next_new_next = next_new_inc;
            win_cnt_next  = win_cnt_reg - 5'd1;
        end
        if (ctl.send_done)
        begin
            valid_next  = '0;
            active_next = 1'b0;
        end
    end

    // ordered scan for resends
    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        min1_next      = min1_reg;
        min2_next      = min2_reg;
        has1_next      = has1_reg;
        has2_next      = has2_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        if (ctl.scan_first || ctl.scan_next)
        begin
            scan_idx_next = '0;
            has1_next     = 1'b0;
            has2_next     = 1'b0;
        end
        else if (ctl.scan_step)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
            if (cand)
            begin
                if (!has1_reg)
                begin
                    min1_next = scan_num;
                    has1_next = 1'b1;
                end
                else if (scan_num < min1_reg)
                begin
                    min2_next = min1_reg;
                    has2_next = 1'b1;
                    min1_next = scan_num;
                end
                else if (scan_num > min1_reg && (!has2_reg || scan_num < min2_reg))
                begin
                    min2_next = scan_num;
                    has2_next = 1'b1;
                end
            end
        end
        if (ctl.scan_first)
        begin
            have_prev_next = 1'b0;
        end
        if (ctl.send_resend)
        begin
            prev_next      = min1_reg;
            have_prev_next = 1'b1;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (ctl.send_new || ctl.send_resend || ctl.send_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (!send_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.send_new)
        begin
            out_item_next.frame_number = next_new_reg;
            out_item_next.send_kind    = srsw_pkg::KIND_NEW;
            out_item_next.last         = ctl.last;
        end
        else if (ctl.send_resend)
        begin
            out_item_next.frame_number = srsw_pkg::FRAME_W'(min1_reg);
            out_item_next.send_kind    = srsw_pkg::KIND_RESEND;
            out_item_next.last         = ctl.last;
        end
        else if (ctl.send_done)
        begin
            out_item_next.frame_number = '0;
            out_item_next.send_kind    = srsw_pkg::KIND_DONE;
            out_item_next.last         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_frames_reg <= srsw_pkg::TOTAL_FRAMES_RST;
            window_size_reg  <= srsw_pkg::WINDOW_SIZE_RST;
            valid_reg        <= '0;
            next_new_reg     <= '0;
            acked_reg        <= '0;
            active_reg       <= 1'b0;
            win_cnt_reg      <= '0;
            scan_idx_reg     <= '0;
            has1_reg         <= 1'b0;
            has2_reg         <= 1'b0;
            have_prev_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            total_frames_reg <= total_frames_next;
            window_size_reg  <= window_size_next;
            valid_reg        <= valid_next;
            next_new_reg     <= next_new_next;
            acked_reg        <= acked_next;
            active_reg       <= active_next;
            win_cnt_reg      <= win_cnt_next;
            scan_idx_reg     <= scan_idx_next;
            has1_reg         <= has1_next;
            has2_reg         <= has2_next;
            have_prev_reg    <= have_prev_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min1_reg     <= min1_next;
        min2_reg     <= min2_next;
        prev_reg     <= prev_next;
        out_item_reg <= out_item_next;
        if (ctl.take)
        begin
            item_reg <= cmd_item;
        end
        if (ctl.send_new && free_found)
        begin
            pend_num_mem[free_idx] <= FRAME_NUMBER_BITS'(next_new_reg);
        end
    end

    assign send_valid = out_valid_reg;
    assign send_item  = out_item_reg;

endmodule

>>> rtl/core/srsw_ctrl.sv
// ----------------------------------------------------------------------------
// srsw_ctrl
// Sequencer for start, ack and timeout requests of the sender window.
// ----------------------------------------------------------------------------
module srsw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                ready,
    input  srsw_pkg::srsw_sts_t sts,
    output srsw_pkg::srsw_ctl_t ctl
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECODE   = 9'b000000010,
        S_START    = 9'b000000100,
        S_ACK_SCAN = 9'b000001000,
        S_ACK_HIT  = 9'b000010000,
        S_ACK_NEW  = 9'b000100000,
        S_DONE     = 9'b001000000,
        S_TO_SCAN  = 9'b010000000,
        S_TO_EMIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   done_after_reg, done_after_next;

    always_comb
    begin
        state_next      = state_reg;
        done_after_next = done_after_reg;
        ctl             = '0;
        ready           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ready    = 1'b1;
                ctl.take = cmd_valid;
                if (cmd_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.command)
                    srsw_pkg::CMD_START:
                    begin
                        ctl.start_init = 1'b1;
                        state_next     = sts.total_zero ? S_DONE : S_START;
                    end
                    srsw_pkg::CMD_ACK:
                    begin
                        ctl.scan_first = sts.active;
                        state_next     = sts.active ? S_ACK_SCAN : S_IDLE;
                    end
                    srsw_pkg::CMD_TIMEOUT:
                    begin
                        ctl.scan_first = sts.active;
                        state_next     = sts.active ? S_TO_SCAN : S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_START:
            begin
                if (sts.can_load)
                begin
                    ctl.send_new = 1'b1;
                    ctl.last     = sts.win_last || sts.new_is_last;
                    if (ctl.last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ACK_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    state_next = S_ACK_HIT;
                end
                else if (sts.scan_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                end
            end
            S_ACK_HIT:
            begin
                ctl.ack_clear   = 1'b1;
                done_after_next = sts.ack_done;
                if (sts.more_new)
                begin
                    state_next = S_ACK_NEW;
                end
                else if (sts.ack_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ACK_NEW:
            begin
                if (sts.can_load)
                begin
                    ctl.send_new = 1'b1;
                    ctl.last     = !done_after_reg;
                    state_next   = done_after_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE:
            begin
                if (sts.can_load)
                begin
                    ctl.send_done = 1'b1;
                    ctl.last      = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TO_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = S_TO_EMIT;
                end
            end
            S_TO_EMIT:
            begin
                if (!sts.has1)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.can_load)
                begin
                    ctl.send_resend = 1'b1;
                    ctl.last        = !sts.has2;
                    ctl.scan_next   = sts.has2;
                    state_next      = sts.has2 ? S_TO_SCAN : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_after_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            done_after_reg <= done_after_next;
        end
    end

endmodule

>>> rtl/core/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender window of selective-repeat ARQ: issues new frames, retires acked
// frames, resends pending frames in ascending order and marks completion.
//
//   channel   valid       stall       payload
//   request   cmd_valid   cmd_stall   cmd_item  (command, ack_frame)
//   result    send_valid  send_stall  send_item (frame_number, send_kind, last)
//   config    cfg_we      -           cfg_index, cfg_data
//
// One request is taken at a time; the next is taken the cycle after the last
// result is loaded into the output register (or its work ends, if it has none).
// Ack and timeout scan the table one entry per cycle; a timeout runs one full
// scan for each resend, in ascending frame order.
// Reset clears control state and all pending valid bits at once.
// send_stall holds a valid result and pauses the sequencer only when it sends.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window #(
    parameter int MAX_WINDOW        = 16,
    parameter int FRAME_NUMBER_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  srsw_pkg::cmd_item_t  cmd_item,
    output logic                 send_valid,
    input  logic                 send_stall,
    output srsw_pkg::send_item_t send_item
);

    srsw_pkg::srsw_ctl_t ctl;
    srsw_pkg::srsw_sts_t sts;
    logic                ready;

    srsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .ready     (ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    srsw_datapath #(
        .MAX_WINDOW        (MAX_WINDOW),
        .FRAME_NUMBER_BITS (FRAME_NUMBER_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_item   (cmd_item),
        .ctl        (ctl),
        .sts        (sts),
        .send_valid (send_valid),
        .send_stall (send_stall),
        .send_item  (send_item)
    );

    assign cmd_stall = !ready;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("request taken while previous request still in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        (send_valid && send_item.send_kind == srsw_pkg::KIND_DONE)
            |-> (send_item.frame_number == '0 && send_item.last))
        else $error("done marker with nonzero frame or without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        send_valid |-> (send_item.send_kind == srsw_pkg::KIND_NEW
            || send_item.send_kind == srsw_pkg::KIND_RESEND
            || send_item.send_kind == srsw_pkg::KIND_DONE))
        else $error("invalid send kind");
`endif

endmodule

>>> verif/srsw_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srsw_tb_pkg
// Scoreboard for the selective-repeat sender window testbench: tracks the
// pending-frame table, the transfer counters and the register settings,
// predicts the sends caused by each request and checks every accepted send.
// ----------------------------------------------------------------------------
package srsw_tb_pkg;

    localparam int         WINDOW_SLOTS = 16;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    class send_scoreboard;

        bit [15:0]            slot_frame[WINDOW_SLOTS];
        bit                   slot_busy[WINDOW_SLOTS];
        bit [15:0]            next_frame;
        bit [15:0]            acked;
        bit                   active;
        bit [15:0]            total;
        bit [4:0]             window;
        srsw_pkg::send_item_t expected_sends[$];
        int                   errors;
        int                   requests;
        int                   results;
        int                   kind_seen[3];

        function new();
            total  = srsw_pkg::TOTAL_FRAMES_RST;
            window = srsw_pkg::WINDOW_SIZE_RST;
            clear_slots();
            next_frame = '0;
            acked      = '0;
            active     = 1'b0;
        endfunction

        function void clear_slots();
            foreach (slot_busy[i])
            begin
                slot_busy[i]  = 1'b0;
                slot_frame[i] = '0;
            end
        endfunction

        function void write_register(logic index, bit [15:0] data);
            if (index == srsw_pkg::CFG_TOTAL_FRAMES)
                total = data;
            else
                window = data[4:0];
        endfunction

        function void push_send(bit [15:0] frame, logic [1:0] kind);
            srsw_pkg::send_item_t s;
            s.frame_number = frame;
            s.send_kind    = kind;
            s.last         = 1'b0;
            expected_sends.push_back(s);
        endfunction

        function void issue_new_frame();
            for (int i = 0; i < WINDOW_SLOTS; i++)
            begin
                if (!slot_busy[i])
                begin
                    slot_busy[i]  = 1'b1;
                    slot_frame[i] = next_frame;
                    push_send(next_frame, srsw_pkg::KIND_NEW);
                    next_frame = next_frame + 16'd1;
                    return;
                end
            end
        endfunction

        function void start_transfer();
            int win;
            clear_slots();
            next_frame = '0;
            acked      = '0;
            if (total == 0)
            begin
                active = 1'b0;
                push_send('0, srsw_pkg::KIND_DONE);
                return;
            end
            active = 1'b1;
            win = (window == 0) ? 1 : (window > WINDOW_SLOTS) ? WINDOW_SLOTS : int'(window);
            for (int n = 0; n < win && next_frame < total; n++)
                issue_new_frame();
        endfunction

        function void retire_frame(bit [15:0] frame);
            if (!active)
                return;
            for (int i = 0; i < WINDOW_SLOTS; i++)
            begin
                if (slot_busy[i] && slot_frame[i] == frame)
                begin
                    slot_busy[i] = 1'b0;
                    if (next_frame < total)
                        issue_new_frame();
                    acked = acked + 16'd1;
                    if (acked >= total)
                    begin
                        active = 1'b0;
                        clear_slots();
                        push_send('0, srsw_pkg::KIND_DONE);
                    end
                    return;
                end
            end
        endfunction

        function void resend_pending();
            bit        have_prev;
            bit [15:0] prev;
            int        best;
            if (!active)
                return;
            have_prev = 1'b0;
            prev      = '0;
            while (1)
            begin
                best = -1;
                for (int i = 0; i < WINDOW_SLOTS; i++)
                begin
                    if (!slot_busy[i])
                        continue;
                    if (have_prev && slot_frame[i] <= prev)
                        continue;
                    if (best < 0 || slot_frame[i] < slot_frame[best])
                        best = i;
                end
                if (best < 0)
                    break;
                push_send(slot_frame[best], srsw_pkg::KIND_RESEND);
                prev      = slot_frame[best];
                have_prev = 1'b1;
            end
        endfunction

        function int note_request(srsw_pkg::cmd_item_t req);
            int prior_size;
            prior_size = expected_sends.size();
            requests++;
            case (req.command)
                srsw_pkg::CMD_START:   start_transfer();
                srsw_pkg::CMD_ACK:     retire_frame(req.ack_frame);
                srsw_pkg::CMD_TIMEOUT: resend_pending();
                default:               ;
            endcase
            if (expected_sends.size() > prior_size)
                expected_sends[expected_sends.size() - 1].last = 1'b1;
            return expected_sends.size() - prior_size;
        endfunction

        function void check_result(srsw_pkg::send_item_t got);
            srsw_pkg::send_item_t want;
            results++;
            if (got.send_kind <= srsw_pkg::KIND_DONE)
                kind_seen[got.send_kind]++;
            if (expected_sends.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected send: expected none, actual frame %0d kind %0d last %0d",
                         $time, got.frame_number, got.send_kind, got.last);
                return;
            end
            want = expected_sends.pop_front();
            if (got.frame_number !== want.frame_number)
            begin
                errors++;
                $display("%0t: frame_number mismatch: expected %0d, actual %0d",
                         $time, want.frame_number, got.frame_number);
            end
            if (got.send_kind !== want.send_kind)
            begin
                errors++;
                $display("%0t: send_kind mismatch: expected %0d, actual %0d",
                         $time, want.send_kind, got.send_kind);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $display("%0t: last mismatch: expected %0d, actual %0d",
                         $time, want.last, got.last);
            end
        endfunction

        function bit pick_pending(output bit [15:0] frame);
            bit [15:0] busy_frames[$];
            frame = '0;
            foreach (slot_busy[i])
                if (slot_busy[i])
                    busy_frames.push_back(slot_frame[i]);
            if (busy_frames.size() == 0)
                return 1'b0;
            frame = busy_frames[$urandom_range(busy_frames.size() - 1)];
            return 1'b1;
        endfunction

    endclass

endpackage

>>> verif/tb_selective_repeat_sender_window.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_sender_window
// Drives start, ack, timeout and unused requests into the sender window under
// changing window and transfer-length settings and varying idle and stall
// patterns, and checks every send against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_selective_repeat_sender_window;

    localparam int RANDOM_ITEMS = 110;
    localparam int PHASE_STEPS  = 30;
    localparam int SETTLE       = 64;
    localparam int HOLD_LEN     = 400;
    localparam int CYCLE_LIMIT  = 600000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [15:0]          cfg_data;
    logic                 cmd_valid;
    logic                 cmd_stall;
    srsw_pkg::cmd_item_t  cmd_item;
    logic                 send_valid;
    logic                 send_stall;
    srsw_pkg::send_item_t send_item;

    srsw_tb_pkg::send_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_seq;
    int cycle_count;
    int counted_items;
    int reg_writes;

    int sender_idle_by_mode[4]   = '{0, 72, 0, 33};
    int receiver_stall_by_mode[4] = '{0, 0, 72, 33};

    selective_repeat_sender_window i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .send_valid (send_valid),
        .send_stall (send_stall),
        .send_item  (send_item)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin : receiver
        int seen;
        int stall_left;
        seen       = 0;
        stall_left = 0;
        send_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != seen)
            begin
                seen       = hold_seq;
                stall_left = HOLD_LEN;
            end
            if (stall_left > 0)
            begin
                send_stall <= 1'b1;
                stall_left--;
            end
            else
                send_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && send_valid && !send_stall)
            sb.check_result(send_item);
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d sends still expected",
                 $time, cycle_count, sb.expected_sends.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_request(logic [1:0] command, bit [15:0] frame, output int produced);
        srsw_pkg::cmd_item_t req;
        req.command   = command;
        req.ack_frame = frame;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= req;
        do
            @(posedge clk);
        while (cmd_stall);
        produced = sb.note_request(req);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (sb.expected_sends.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_register(logic index, bit [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_register(index, data);
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic run_directed();
        int k;
        send_request(srsw_pkg::CMD_START, 16'h5A5A, k);
        send_request(srsw_pkg::CMD_ACK, 16'd0, k);
        send_request(srsw_pkg::CMD_ACK, 16'd2, k);
        send_request(srsw_pkg::CMD_ACK, 16'd0, k);
        send_request(srsw_pkg::CMD_TIMEOUT, 16'd0, k);
        send_request(srsw_tb_pkg::CMD_UNUSED, 16'hFFFF, k);
        send_request(srsw_pkg::CMD_ACK, 16'hFFFF, k);
        send_request(srsw_pkg::CMD_START, 16'd0, k);
        wait_drained();
        write_register(srsw_pkg::CFG_TOTAL_FRAMES, 16'd0);
        send_request(srsw_pkg::CMD_START, 16'd0, k);
        send_request(srsw_pkg::CMD_ACK, 16'd0, k);
        send_request(srsw_pkg::CMD_TIMEOUT, 16'hA5A5, k);
        wait_drained();
        write_register(srsw_pkg::CFG_TOTAL_FRAMES, 16'd2);
        write_register(srsw_pkg::CFG_WINDOW_SIZE, 16'hFFE0);
        send_request(srsw_pkg::CMD_START, 16'd0, k);
        send_request(srsw_pkg::CMD_ACK, 16'd0, k);
        send_request(srsw_pkg::CMD_ACK, 16'd1, k);
        wait_drained();
        write_register(srsw_pkg::CFG_TOTAL_FRAMES, 16'hFFFF);
        write_register(srsw_pkg::CFG_WINDOW_SIZE, 16'd31);
        send_request(srsw_pkg::CMD_START, 16'd0, k);
        send_request(srsw_pkg::CMD_TIMEOUT, 16'd0, k);
        send_request(srsw_pkg::CMD_ACK, 16'd15, k);
        wait_drained();
        write_register(srsw_pkg::CFG_TOTAL_FRAMES, 16'd3);
        send_request(srsw_pkg::CMD_ACK, 16'd0, k);
        send_request(srsw_pkg::CMD_ACK, 16'd1, k);
        wait_drained();
    endtask

    task automatic run_phase(int phase_no);
        int        mode;
        int        steps;
        int        roll;
        int        k;
        bit [15:0] f;
        bit [15:0] junk;
        bit [4:0]  win;
        mode = phase_no % 4;
        sender_idle_pct    = sender_idle_by_mode[mode];
        receiver_stall_pct = receiver_stall_by_mode[mode];
        roll = $urandom_range(99);
        if (roll < 70)
            write_register(srsw_pkg::CFG_TOTAL_FRAMES, 16'($urandom_range(1, 10)));
        else if (roll < 80)
            write_register(srsw_pkg::CFG_TOTAL_FRAMES, 16'd0);
        else if (roll < 95)
            write_register(srsw_pkg::CFG_TOTAL_FRAMES, 16'($urandom_range(11, 40)));
        else
            write_register(srsw_pkg::CFG_TOTAL_FRAMES, 16'hFFFF);
        if ($urandom_range(1) == 0)
        begin
            roll = $urandom_range(9);
            win  = (roll == 0) ? 5'd0 : (roll == 1) ? 5'd31 : (roll == 2) ? 5'd16 :
                   5'($urandom_range(0, 31));
            junk = 16'($urandom);
            write_register(srsw_pkg::CFG_WINDOW_SIZE, {junk[15:5], win});
        end
        if (phase_no == 2)
            hold_seq++;
        if (!sb.active || $urandom_range(3) != 0)
        begin
            send_request(srsw_pkg::CMD_START, 16'($urandom), k);
            counted_items += (k > 0);
        end
        steps = 0;
        while (sb.active && steps < PHASE_STEPS && sb.requests < RANDOM_ITEMS)
        begin
            roll = $urandom_range(99);
            if (roll < 72 && sb.pick_pending(f))
                send_request(srsw_pkg::CMD_ACK, f, k);
            else if (roll < 82)
                send_request(srsw_pkg::CMD_TIMEOUT, 16'($urandom), k);
            else if (roll < 91)
                send_request(srsw_pkg::CMD_ACK, 16'($urandom), k);
            else if (roll < 95)
                send_request(srsw_tb_pkg::CMD_UNUSED, 16'($urandom), k);
            else
                send_request(srsw_pkg::CMD_START, 16'($urandom), k);
            counted_items += (k > 0);
            steps++;
        end
        if ($urandom_range(3) == 0)
            send_request(2'($urandom_range(1, 3)), 16'($urandom), k);
        wait_drained();
    endtask

    initial
    begin : stimulus
        int phase_no;
        sb = new();
        hold_seq           = 0;
        counted_items      = 0;
        reg_writes         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        cmd_valid = 1'b0;
        cmd_item  = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        phase_no = 0;
        while (sb.requests < RANDOM_ITEMS)
        begin
            run_phase(phase_no);
            phase_no++;
        end
        wait_drained();

        if (sb.expected_sends.size() > 0)
        begin
            sb.errors += sb.expected_sends.size();
            $display("%0t: %0d expected sends never arrived", $time, sb.expected_sends.size());
        end
        $display("Ran %0d requests (%0d random ones with sends) over %0d phases, %0d reg writes.",
                 sb.requests, counted_items, phase_no, reg_writes);
        $display("Checked %0d sends: %0d new, %0d resent, %0d completion markers; %0d errors.",
                 sb.results, sb.kind_seen[srsw_pkg::KIND_NEW],
                 sb.kind_seen[srsw_pkg::KIND_RESEND],
                 sb.kind_seen[srsw_pkg::KIND_DONE], sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
